[sv/pnaht_pkg.sv]
// ----------------------------------------------------------------------------
// pnaht_pkg
// Shared codes and default sizes for the port/NIC association table.
// ----------------------------------------------------------------------------
package pnaht_pkg;

    localparam int BUCKETS_DEF    = 512;
    localparam int POOL_NODES_DEF = 1024;
    localparam int USED_WORD_MAX  = 32;   // most bits per word of the slot-used map

    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_CREATED = 3'd1,
        ST_NO_ROOM = 3'd2,
        ST_REMOVED = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

endpackage

[sv/pnaht_ram.sv]
// ----------------------------------------------------------------------------
// pnaht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pnaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/port_nic_assoc_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// port_nic_assoc_hash_table_unit
// Hash table keyed by (port id, NIC index) with chained buckets and a
// bounded node pool; get-or-create, set, delete and clear requests.
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  request   i_valid / o_ready, i_req_type, i_port_id,        in
//            i_nic_index, i_interface_handle
//  result    o_valid / i_ready, o_status, o_slot,             out
//            o_stored_interface, o_oid_flag
//
//  States, accept to next ready: a hit goes S_HEAD, S_NODE per node walked,
//  S_OUT; a miss (absent, no_room) adds S_MISS, the miss decision, and a
//  delete hit adds S_FREE, the used-map free; a create adds S_ALLOC and
//  S_LINK beyond a miss. The walk is one node-memory read per node.
//  Clear and reset sweep the bucket memory and the used map; no request
//  is taken during the sweep.
//  Reset is synchronous, active low. A result waits in the output register
//  while the next request is taken; the block stalls only if a second
//  result is ready before the first has been taken.
//  BUCKETS and POOL_NODES are powers of two.
// ----------------------------------------------------------------------------
module port_nic_assoc_hash_table_unit
    import pnaht_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_port_id,
    input  logic [15:0] i_nic_index,
    input  logic [15:0] i_interface_handle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [15:0] o_stored_interface,
    output logic        o_oid_flag
);

    // sizes
    localparam int BW     = $clog2(BUCKETS);
    localparam int PW     = $clog2(POOL_NODES);
    localparam int PTRW   = PW + 1;                 // 0 = none, else slot+1
    localparam int UW     = (POOL_NODES < USED_WORD_MAX) ? POOL_NODES : USED_WORD_MAX;
    localparam int UWL    = $clog2(UW);
    localparam int NWORDS = POOL_NODES / UW;
    localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CLRN   = (BUCKETS > NWORDS) ? BUCKETS : NWORDS;
    localparam int CW     = $clog2(CLRN) + 1;
    // node word: {next, port, nic, iface, flag}
    localparam int NODE_W = PTRW + 32 + 16 + 16 + 1;
    localparam int F_LSB  = 0;
    localparam int I_LSB  = 1;
    localparam int N_LSB  = 17;
    localparam int P_LSB  = 33;
    localparam int X_LSB  = 65;

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_HEAD  = 10'b0000000100,
        S_NODE  = 10'b0000001000,
        S_MISS  = 10'b0000010000,
        S_ALLOC = 10'b0000100000,
        S_LINK  = 10'b0001000000,
        S_FREE  = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } t_state;

    t_state r_state;

    // latched request
    t_req              r_req;
    logic [31:0]       r_port;
    logic [15:0]       r_nic;
    logic [15:0]       r_handle;
    logic [BW-1:0]     r_bkt;
    // walk
    logic [PTRW-1:0]   r_cur;
    logic [PTRW-1:0]   r_prev;        // predecessor of match, or tail on a miss
    logic [NODE_W-1:0] r_prev_word;
    logic [WW-1:0]     r_word;
    logic [PW-1:0]     r_fresh;
    logic [NWORDS-1:0] r_full;        // used-map word has no free bit
    logic [CW-1:0]     r_idx;
    logic              r_clr_res;
    // staged result
    t_status           r_res_status;
    logic [PW-1:0]     r_res_slot;
    logic [15:0]       r_res_iface;
    logic              r_res_flag;
    // output register
    logic              r_out_valid;
    logic [2:0]        r_o_status;
    logic [9:0]        r_o_slot;
    logic [15:0]       r_o_iface;
    logic              r_o_flag;

    // memory ports
    logic              b_we;
    logic [BW-1:0]     b_waddr;
    logic [PTRW-1:0]   b_wdata;
    logic [BW-1:0]     b_raddr;
    logic [PTRW-1:0]   b_rdata;
    logic              nd_we;
    logic [PW-1:0]     nd_waddr;
    logic [NODE_W-1:0] nd_wdata;
    logic [PW-1:0]     nd_raddr;
    logic [NODE_W-1:0] nd_rdata;
    logic              u_we;
    logic [WW-1:0]     u_waddr;
    logic [UW-1:0]     u_wdata;
    logic [WW-1:0]     u_raddr;
    logic [UW-1:0]     u_rdata;

    logic              accept;
    logic [31:0]       in_sum;
    logic              key_hit;
    logic [PTRW-1:0]   nd_next;
    logic [PW-1:0]     cur_slot;
    logic [WW-1:0]     free_word;
    logic              pool_full;
    logic [UWL-1:0]    free_bit;
    logic [UW-1:0]     cur_mask;
    logic [PW-1:0]     fresh_slot;
    logic              out_load;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_sum   = i_port_id + 32'(i_nic_index);
    assign nd_next  = nd_rdata[X_LSB +: PTRW];
    assign key_hit  = (nd_rdata[P_LSB +: 32] == r_port) && (nd_rdata[N_LSB +: 16] == r_nic);
    assign cur_slot = PW'(r_cur - PTRW'(1));
    assign cur_mask = UW'(1) << cur_slot[UWL-1:0];
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // lowest word of the used map with a free bit
    always_comb begin
        free_word = '0;
        pool_full = 1'b1;
        for (int i = NWORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                free_word = WW'(i);
                pool_full = 1'b0;
            end
        end
    end

    // lowest free bit in the word just read
    always_comb begin
        free_bit = '0;
        for (int i = UW - 1; i >= 0; i--) begin
            if (!u_rdata[i]) begin
                free_bit = UWL'(i);
            end
        end
    end

    assign fresh_slot = PW'(PW'(r_word) << UWL) | PW'(free_bit);

    // memory control
    always_comb begin
        b_we     = 1'b0;
        b_waddr  = r_bkt;
        b_wdata  = '0;
        b_raddr  = in_sum[BW-1:0];
        nd_we    = 1'b0;
        nd_waddr = cur_slot;
        nd_wdata = nd_rdata;
        nd_raddr = PW'(nd_next - PTRW'(1));
        u_we     = 1'b0;
        u_waddr  = r_word;
        u_wdata  = u_rdata;
        u_raddr  = free_word;
        unique case (r_state)
            S_CLR: begin
                b_we    = (r_idx < CW'(BUCKETS));
                b_waddr = r_idx[BW-1:0];
                u_we    = (r_idx < CW'(NWORDS));
                u_waddr = WW'(r_idx);
                u_wdata = '0;
            end
            S_HEAD: begin
                nd_raddr = PW'(b_rdata - PTRW'(1));
            end
            S_NODE: begin
                u_raddr = WW'(cur_slot >> UWL);
                if (key_hit && r_req == REQ_SET) begin
                    nd_we    = 1'b1;
                    nd_waddr = cur_slot;
                    nd_wdata = nd_rdata;
                    nd_wdata[I_LSB +: 16] = r_handle;
                    nd_wdata[F_LSB]       = 1'b1;
                end else if (key_hit && r_req == REQ_DELETE) begin
                    if (r_prev == '0) begin
                        b_we    = 1'b1;
                        b_wdata = nd_next;
                    end else begin
                        nd_we    = 1'b1;
                        nd_waddr = PW'(r_prev - PTRW'(1));
                        nd_wdata = r_prev_word;
                        nd_wdata[X_LSB +: PTRW] = nd_next;
                    end
                end
            end
            S_ALLOC: begin
                u_we     = 1'b1;
                u_wdata  = u_rdata | (UW'(1) << free_bit);
                nd_we    = 1'b1;
                nd_waddr = fresh_slot;
                nd_wdata = {PTRW'(0), r_port, r_nic,
                            (r_req == REQ_SET) ? r_handle : 16'd0,
                            (r_req == REQ_SET)};
            end
            S_LINK: begin
                if (r_prev == '0) begin
                    b_we    = 1'b1;
                    b_wdata = PTRW'(r_fresh) + PTRW'(1);
                end else begin
                    nd_we    = 1'b1;
                    nd_waddr = PW'(r_prev - PTRW'(1));
                    nd_wdata = r_prev_word;
                    nd_wdata[X_LSB +: PTRW] = PTRW'(r_fresh) + PTRW'(1);
                end
            end
            S_FREE: begin
                u_we    = 1'b1;
                u_wdata = u_rdata & ~cur_mask;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_clr_res   <= 1'b0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == CW'(CLRN - 1)) begin
                        r_res_status <= ST_CLEARED;
                        r_state      <= r_clr_res ? S_OUT : S_IDLE;
                    end
                    r_idx <= r_idx + CW'(1);
                end
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= t_req'(i_req_type);
                        r_port   <= i_port_id;
                        r_nic    <= i_nic_index;
                        r_handle <= i_interface_handle;
                        r_bkt    <= in_sum[BW-1:0];
                        r_prev   <= '0;
                        r_res_slot  <= '0;
                        r_res_iface <= '0;
                        r_res_flag  <= 1'b0;
                        if (t_req'(i_req_type) == REQ_CLEAR) begin
                            r_full    <= '0;
                            r_idx     <= '0;
                            r_clr_res <= 1'b1;
                            r_state   <= S_CLR;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_cur   <= b_rdata;
                    r_state <= (b_rdata == '0) ? S_MISS : S_NODE;
                end
                S_NODE: begin
                    if (key_hit) begin
                        if (r_req == REQ_DELETE) begin
                            r_word       <= WW'(cur_slot >> UWL);
                            r_res_status <= ST_REMOVED;
                            r_state      <= S_FREE;
                        end else begin
                            r_res_status <= ST_FOUND;
                            r_res_slot   <= cur_slot;
                            r_res_iface  <= (r_req == REQ_SET) ? r_handle
                                                               : nd_rdata[I_LSB +: 16];
                            r_res_flag   <= (r_req == REQ_SET) ? 1'b1 : nd_rdata[F_LSB];
                            r_state      <= S_OUT;
                        end
                    end else begin
                        r_prev      <= r_cur;
                        r_prev_word <= nd_rdata;
                        r_cur       <= nd_next;
                        r_state     <= (nd_next == '0) ? S_MISS : S_NODE;
                    end
                end
                S_MISS: begin
                    if (r_req == REQ_DELETE) begin
                        r_res_status <= ST_ABSENT;
                        r_state      <= S_OUT;
                    end else if (pool_full) begin
                        r_res_status <= ST_NO_ROOM;
                        r_state      <= S_OUT;
                    end else begin
                        r_word  <= free_word;
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if ((u_rdata | (UW'(1) << free_bit)) == '1) begin
                        r_full[r_word] <= 1'b1;
                    end
                    r_fresh      <= fresh_slot;
                    r_res_status <= ST_CREATED;
                    r_res_slot   <= fresh_slot;
                    r_res_iface  <= (r_req == REQ_SET) ? r_handle : 16'd0;
                    r_res_flag   <= (r_req == REQ_SET);
                    r_state      <= S_LINK;
                end
                S_LINK: begin
                    r_state <= S_OUT;
                end
                S_FREE: begin
                    r_full[r_word] <= 1'b0;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_clr_res <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= 10'(r_res_slot);
            r_o_iface  <= r_res_iface;
            r_o_flag   <= r_res_flag;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_o_status;
    assign o_slot             = r_o_slot;
    assign o_stored_interface = r_o_iface;
    assign o_oid_flag         = r_o_flag;

    pnaht_ram #(.WIDTH(PTRW), .DEPTH(BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    pnaht_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    pnaht_ram #(.WIDTH(UW), .DEPTH(NWORDS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

`ifndef SYNTH
    // no_room only when every used-map word is full
    a_noroom_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_status == ST_NO_ROOM) |-> (r_full == '1))
        else $error("no_room with a free word");

    // results without an entry carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REMOVED || o_status == ST_ABSENT ||
                     o_status == ST_CLEARED || o_status == ST_NO_ROOM))
        |-> (o_slot == '0 && o_stored_interface == '0 && !o_oid_flag))
        else $error("payload on a result without entry");

    // a walk never issues a node write except on a match
    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE && !key_hit) |-> (!nd_we && !b_we))
        else $error("write during chain walk");

    // a new node is allocated only in a used-map word with a free bit
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (u_rdata != '1))
        else $error("allocation in a full used word");
`endif

endmodule
